### src/sle_pkg.sv
// Package for the sorted list engine: sizes, codes and word types.
package sle_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;

    // Operation codes
    localparam logic [2:0] OP_INSERT       = 3'd0;
    localparam logic [2:0] OP_SEARCH       = 3'd1;
    localparam logic [2:0] OP_REMOVE       = 3'd2;
    localparam logic [2:0] OP_REMOVE_FIRST = 3'd3;
    localparam logic [2:0] OP_REMOVE_LAST  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Request word
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [CNT_W-1:0]   occupancy;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic walk;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic out_free;
    } t_stat;

endpackage

### src/sle_ctrl.sv
// Controller state machine for the sorted list engine.
module sle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  sle_pkg::t_stat   i_stat,
    output logic             o_in_stall,
    output sle_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // One request at a time: take a word only when idle
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.walk   = (r_state == S_WALK);
    assign o_cmd.finish = (r_state == S_FIN) && i_stat.out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_stat.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/sle_datapath.sv
// Datapath for the sorted list engine: table memory, walk pointer, result register.
module sle_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sle_pkg::t_cmd       i_cmd,
    input  sle_pkg::t_in_word   i_in_word,
    input  logic                i_out_stall,
    output sle_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output sle_pkg::t_out_word  o_out_word
);

    localparam int IW = sle_pkg::IDX_W;
    localparam int CW = sle_pkg::CNT_W;

    // Table storage
    logic [31:0] r_mem [sle_pkg::TABLE_DEPTH];
    logic [31:0] r_rdata;

    // Request and walk state
    logic [CW-1:0]      r_count;
    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic [IW-1:0]      r_ptr;
    logic [IW-1:0]      r_didx;
    logic               r_dv;
    logic               r_issuing;
    logic               r_found;
    logic [IW-1:0]      r_ins_pos;
    logic [31:0]        r_removed;

    // Result register
    logic               r_out_valid;
    sle_pkg::t_out_word r_out_word;

    logic          full;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] last_up;
    logic          desc;
    logic          issue;
    logic          issue_last;
    logic          q_lt_v;
    logic          q_eq_v;
    logic          dv_done;
    logic          proc;
    logic          no_walk;
    logic          in_desc;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign full    = (r_count == CW'(sle_pkg::TABLE_DEPTH));
    assign cnt_m1  = r_count - CW'(1);
    assign last_up = cnt_m1[IW-1:0];
    assign desc    = (r_op == sle_pkg::OP_INSERT) || (r_op == sle_pkg::OP_REMOVE_LAST);
    assign q_lt_v  = $signed(r_rdata) < r_val;
    assign q_eq_v  = (r_rdata == r_val);
    assign proc    = i_cmd.walk && r_dv;

    // Decide at request time whether any entry must be read
    always_comb begin
        no_walk = (r_count == '0);
        case (i_in_word.operation)
            sle_pkg::OP_INSERT:       no_walk = (r_count == '0) || full;
            sle_pkg::OP_SEARCH,
            sle_pkg::OP_REMOVE,
            sle_pkg::OP_REMOVE_FIRST,
            sle_pkg::OP_REMOVE_LAST:  no_walk = (r_count == '0);
            default:                  no_walk = 1'b1;
        endcase
        in_desc = (i_in_word.operation == sle_pkg::OP_INSERT) ||
                  (i_in_word.operation == sle_pkg::OP_REMOVE_LAST);
    end

    // Read issue: one entry a cycle, upward or downward
    assign issue      = i_cmd.walk && r_issuing;
    assign issue_last = (r_op == sle_pkg::OP_REMOVE_LAST) ||
                        (desc ? (r_ptr == '0) : (r_ptr == last_up));

    // End of walk, judged on the word just returned
    always_comb begin
        case (r_op)
            sle_pkg::OP_INSERT:      dv_done = q_lt_v || (r_didx == '0);
            sle_pkg::OP_SEARCH:      dv_done = q_eq_v || (r_didx == last_up);
            sle_pkg::OP_REMOVE_LAST: dv_done = 1'b1;
            default:                 dv_done = (r_didx == last_up);
        endcase
    end

    assign o_stat.done     = r_dv ? dv_done : !r_issuing;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Write port: shift during the walk, new value at finish
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_didx;
        wr_data = r_rdata;
        if (i_cmd.finish) begin
            wr_en   = (r_op == sle_pkg::OP_INSERT) && !full;
            wr_addr = r_ins_pos;
            wr_data = r_val;
        end else if (proc) begin
            case (r_op)
                sle_pkg::OP_INSERT: begin
                    wr_en   = !q_lt_v;
                    wr_addr = r_didx + IW'(1);
                end
                sle_pkg::OP_REMOVE,
                sle_pkg::OP_REMOVE_FIRST: begin
                    wr_en   = r_found;
                    wr_addr = r_didx - IW'(1);
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_ptr];
    end

    // Walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv      <= 1'b0;
            r_issuing <= 1'b0;
        end else begin
            r_dv <= issue;
            if (i_cmd.start) begin
                r_issuing <= !no_walk;
            end else if (issue && issue_last) begin
                r_issuing <= 1'b0;
            end
        end
    end

    // Request latch, pointer and per-word bookkeeping
    always_ff @(posedge i_clk) begin
        r_didx <= r_ptr;
        if (i_cmd.start) begin
            r_op      <= i_in_word.operation;
            r_val     <= i_in_word.operand_value;
            r_ptr     <= in_desc ? last_up : '0;
            r_found   <= 1'b0;
            r_ins_pos <= '0;
            r_removed <= '0;
        end else begin
            if (issue) begin
                r_ptr <= desc ? (r_ptr - IW'(1)) : (r_ptr + IW'(1));
            end
            if (proc) begin
                case (r_op)
                    sle_pkg::OP_INSERT: begin
                        if (q_lt_v) r_ins_pos <= r_didx + IW'(1);
                    end
                    sle_pkg::OP_SEARCH: begin
                        if (q_eq_v) r_found <= 1'b1;
                    end
                    sle_pkg::OP_REMOVE: begin
                        if (q_eq_v) r_found <= 1'b1;
                    end
                    sle_pkg::OP_REMOVE_FIRST: begin
                        if (r_didx == '0) begin
                            r_found   <= 1'b1;
                            r_removed <= r_rdata;
                        end
                    end
                    sle_pkg::OP_REMOVE_LAST: begin
                        r_removed <= r_rdata;
                    end
                    default: begin
                        r_found <= r_found;
                    end
                endcase
            end
        end
    end

    // Count and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                case (r_op)
                    sle_pkg::OP_INSERT: begin
                        if (!full) r_count <= r_count + CW'(1);
                    end
                    sle_pkg::OP_REMOVE: begin
                        if (r_found) r_count <= cnt_m1;
                    end
                    sle_pkg::OP_REMOVE_FIRST,
                    sle_pkg::OP_REMOVE_LAST: begin
                        if (r_count != '0) r_count <= cnt_m1;
                    end
                    default: begin
                        r_count <= r_count;
                    end
                endcase
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_word.removed_value <= '0;
            r_out_word.occupancy     <= r_count;
            case (r_op)
                sle_pkg::OP_INSERT: begin
                    r_out_word.status <= full ? sle_pkg::ST_FULL : sle_pkg::ST_OK;
                    if (!full) r_out_word.occupancy <= r_count + CW'(1);
                end
                sle_pkg::OP_SEARCH: begin
                    r_out_word.status <= r_found ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
                end
                sle_pkg::OP_REMOVE: begin
                    r_out_word.status <= r_found ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
                    if (r_found) r_out_word.occupancy <= cnt_m1;
                end
                sle_pkg::OP_REMOVE_FIRST,
                sle_pkg::OP_REMOVE_LAST: begin
                    if (r_count == '0) begin
                        r_out_word.status <= sle_pkg::ST_EMPTY;
                    end else begin
                        r_out_word.status        <= sle_pkg::ST_OK;
                        r_out_word.removed_value <= r_removed;
                        r_out_word.occupancy     <= cnt_m1;
                    end
                end
                default: begin
                    r_out_word.status <= sle_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### src/sorted_list_engine.sv
// A request reads the stored entries one by one before its result is registered: search stops at
// the matching entry, insert at the first entry below its value, remove last reads only the last
// entry, and an empty table, insert on a full table or an unused code reads none. The table memory
// reads one entry a cycle. A new word waits while a request is in progress.
// Reset (synchronous, active low) empties the table and clears the result valid flag.
// Table contents are not cleared; entries at or above the occupancy are never read.
module sorted_list_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sle_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sle_pkg::t_out_word  o_out_word
);

    sle_pkg::t_cmd  cmd;
    sle_pkg::t_stat stat;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sle_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### src/sle_checker.sv
// Port-level assertions for the sorted list engine, bound to the top level.
module sle_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sle_pkg::t_out_word  o_out_word
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // Only one request in flight: input is stalled right after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second word accepted during a request");

    // A result never appears in the cycle right after acceptance
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Occupancy stays within the table
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.occupancy <= sle_pkg::CNT_W'(sle_pkg::TABLE_DEPTH)))
        else $error("occupancy beyond table depth");

    // A removed value is reported only with an ok status
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != sle_pkg::ST_OK)) |->
        (o_out_word.removed_value == '0))
        else $error("removed value set on a failed request");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);

### sim/sorted_list_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_list_engine: directed request table, then random traffic.
module sorted_list_engine_tb;

    // Operation codes the block does not define; they must leave the table alone
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam int DIR_ROWS      = 24;
    localparam int RANDOM_WORDS  = 600;
    localparam int QUIET_WORDS   = 80;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum {MODE_MIXED, MODE_FILL, MODE_DRAIN} t_mode;

    // One directed request; res is used only where typed is set
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] val;
        bit                 typed;
        sle_pkg::t_out_word res;
    } t_dir_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    sle_pkg::t_in_word  i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    sle_pkg::t_out_word o_out_word;

    // Shadow copy of the sorted table
    logic signed [31:0] list_vals [sle_pkg::TABLE_DEPTH];
    int                 list_len = 0;

    sle_pkg::t_out_word result_q [$];
    int        fail_cnt   = 0;
    int        words_sent = 0;
    int        cycle_cnt  = 0;
    int        hold_cnt   = 0;
    bit        src_gaps   = 1'b1;
    bit        snk_gaps   = 1'b1;
    bit        quiet      = 1'b0;

    // Directed requests: empty-table cases, extremes, duplicates, spare codes, back to empty
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{sle_pkg::OP_REMOVE_FIRST, 32'sh0000_0000, 1'b1,
          '{sle_pkg::ST_EMPTY, 32'sh0, 7'd0}},
        '{sle_pkg::OP_REMOVE_LAST, 32'sh7FFF_FFFF, 1'b1,
          '{sle_pkg::ST_EMPTY, 32'sh0, 7'd0}},
        '{sle_pkg::OP_SEARCH, 32'sh0000_0000, 1'b1,
          '{sle_pkg::ST_NOT_FOUND, 32'sh0, 7'd0}},
        '{sle_pkg::OP_REMOVE, 32'shFFFF_FFFF, 1'b1,
          '{sle_pkg::ST_NOT_FOUND, 32'sh0, 7'd0}},
        '{OP_SPARE_A, 32'sh8000_0000, 1'b1,
          '{sle_pkg::ST_OK, 32'sh0, 7'd0}},
        '{sle_pkg::OP_INSERT, 32'sh7FFF_FFFF, 1'b1,
          '{sle_pkg::ST_OK, 32'sh0, 7'd1}},
        '{sle_pkg::OP_INSERT, 32'sh8000_0000, 1'b1,
          '{sle_pkg::ST_OK, 32'sh0, 7'd2}},
        '{sle_pkg::OP_INSERT,       32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_INSERT,       32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_INSERT,       32'shFFFF_FFFF, 1'b0, '0},
        '{sle_pkg::OP_SEARCH,       32'sh8000_0000, 1'b0, '0},
        '{sle_pkg::OP_SEARCH,       32'sh0000_0005, 1'b0, '0},
        '{OP_SPARE_B,               32'shFFFF_FFFF, 1'b0, '0},
        '{sle_pkg::OP_REMOVE,       32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_REMOVE,       32'sh0000_0007, 1'b0, '0},
        '{sle_pkg::OP_REMOVE_FIRST, 32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_REMOVE_LAST,  32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_INSERT,       32'sh0000_0001, 1'b0, '0},
        '{OP_SPARE_C,               32'sh1234_5678, 1'b0, '0},
        '{sle_pkg::OP_SEARCH,       32'sh7FFF_FFFF, 1'b0, '0},
        '{sle_pkg::OP_REMOVE,       32'shFFFF_FFFF, 1'b0, '0},
        '{sle_pkg::OP_REMOVE_LAST,  32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_REMOVE_FIRST, 32'sh0000_0000, 1'b0, '0},
        '{sle_pkg::OP_REMOVE_LAST, 32'shFFFF_FFFF, 1'b1,
          '{sle_pkg::ST_EMPTY, 32'sh0, 7'd0}}
    };

    sorted_list_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // Position of the first stored value equal to v, list_len if absent
    function automatic int find_first(input logic signed [31:0] v);
        int pos;
        pos = 0;
        while (pos < list_len && list_vals[pos] != v) pos++;
        return pos;
    endfunction

    // Close the gap left at pos
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
        list_len--;
    endfunction

    // Apply one request to the shadow table and return the result word it gives
    function automatic sle_pkg::t_out_word apply_request(input sle_pkg::t_in_word w);
        sle_pkg::t_out_word r;
        int                 pos;
        int                 i;
        r = '0;
        r.status = sle_pkg::ST_OK;
        case (w.operation)
            sle_pkg::OP_INSERT: begin
                if (list_len >= sle_pkg::TABLE_DEPTH) begin
                    r.status = sle_pkg::ST_FULL;
                end else begin
                    // ahead of the first value not below it, so equal values stay in order
                    pos = 0;
                    while (pos < list_len && list_vals[pos] < w.operand_value) pos++;
                    for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i - 1];
                    list_vals[pos] = w.operand_value;
                    list_len++;
                end
            end
            sle_pkg::OP_SEARCH: begin
                if (find_first(w.operand_value) >= list_len) r.status = sle_pkg::ST_NOT_FOUND;
            end
            sle_pkg::OP_REMOVE: begin
                pos = find_first(w.operand_value);
                if (pos >= list_len) r.status = sle_pkg::ST_NOT_FOUND;
                else drop_entry(pos);
            end
            sle_pkg::OP_REMOVE_FIRST: begin
                if (list_len == 0) begin
                    r.status = sle_pkg::ST_EMPTY;
                end else begin
                    r.removed_value = list_vals[0];
                    drop_entry(0);
                end
            end
            sle_pkg::OP_REMOVE_LAST: begin
                if (list_len == 0) begin
                    r.status = sle_pkg::ST_EMPTY;
                end else begin
                    r.removed_value = list_vals[list_len - 1];
                    list_len--;
                end
            end
            default: ;
        endcase
        r.occupancy = sle_pkg::CNT_W'(list_len);
        return r;
    endfunction

    // Operation mix per traffic mode
    function automatic logic [2:0] pick_op(input t_mode m);
        int r;
        r = $urandom_range(0, 99);
        case (m)
            MODE_FILL: begin
                if (r < 85) return sle_pkg::OP_INSERT;
                if (r < 95) return sle_pkg::OP_SEARCH;
                return sle_pkg::OP_REMOVE;
            end
            MODE_DRAIN: begin
                if (r < 30) return sle_pkg::OP_REMOVE_FIRST;
                if (r < 60) return sle_pkg::OP_REMOVE_LAST;
                if (r < 90) return sle_pkg::OP_REMOVE;
                return sle_pkg::OP_SEARCH;
            end
            default: begin
                if (r < 40) return sle_pkg::OP_INSERT;
                if (r < 60) return sle_pkg::OP_SEARCH;
                if (r < 78) return sle_pkg::OP_REMOVE;
                if (r < 87) return sle_pkg::OP_REMOVE_FIRST;
                if (r < 96) return sle_pkg::OP_REMOVE_LAST;
                case ($urandom_range(0, 2))
                    0:       return OP_SPARE_A;
                    1:       return OP_SPARE_B;
                    default: return OP_SPARE_C;
                endcase
            end
        endcase
    endfunction

    // Operand: stored values for hits, a narrow band for duplicates, extremes, full range
    function automatic logic signed [31:0] pick_value(input bit prefer_stored);
        logic signed [31:0] v;
        int                 r;
        r = $urandom_range(0, 9);
        v = $urandom;
        if (r < 4 && prefer_stored && list_len > 0) begin
            v = list_vals[$urandom_range(0, list_len - 1)];
        end else if (r < 6) begin
            v = $urandom_range(0, 16);
            v = v - 32'sd8;
        end else if (r == 6) begin
            case ($urandom_range(0, 3))
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = 32'sh0000_0000;
                default: v = 32'shFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    // Drive one request word, wait for it to be taken, queue its expected result
    task automatic send_req(input logic [2:0] op, input logic signed [31:0] val,
                            input bit typed, input sle_pkg::t_out_word typed_res);
        sle_pkg::t_in_word  w;
        sle_pkg::t_out_word predicted;
        w.operation     = op;
        w.operand_value = val;
        if (src_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_request(w);
        result_q.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin : stimulus
        int          k;
        int          seg;
        int          extra;
        int          seg_len;
        bit          seg_done;
        t_mode       mode;
        logic [2:0]  op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_req(dir_rows[k].op, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].res);
        wait_drained();

        // Random traffic in segments: fill to full, drain to empty, mixed runs
        words_sent = 0;
        seg = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (seg == 0) begin
                mode = MODE_FILL;
            end else if (seg == 1) begin
                mode = MODE_DRAIN;
            end else begin
                case ($urandom_range(0, 3))
                    0:       mode = MODE_FILL;
                    1:       mode = MODE_DRAIN;
                    default: mode = MODE_MIXED;
                endcase
            end
            quiet    = (words_sent >= RANDOM_WORDS - QUIET_WORDS);
            src_gaps = ($urandom_range(0, 2) != 0);
            snk_gaps = ($urandom_range(0, 2) != 0);
            if (!quiet && seg > 1 && $urandom_range(0, 5) == 0) wait_drained();
            extra    = $urandom_range(1, 4);
            seg_len  = $urandom_range(20, 60);
            seg_done = 1'b0;
            while (!seg_done) begin
                op = pick_op(mode);
                send_req(op, pick_value(op != sle_pkg::OP_INSERT), 1'b0, '0);
                case (mode)
                    // a few extra requests once the table is full, or empty
                    MODE_FILL: begin
                        if (list_len == sle_pkg::TABLE_DEPTH) extra--;
                        seg_done = (extra == 0);
                    end
                    MODE_DRAIN: begin
                        if (list_len == 0) extra--;
                        seg_done = (extra == 0);
                    end
                    default: begin
                        seg_len--;
                        seg_done = (seg_len == 0);
                    end
                endcase
            end
            seg++;
        end

        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && result_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Random receiver stall bursts
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (snk_gaps && !quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= $urandom_range(0, 9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        sle_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $error("result word with none expected: status %0d removed_value %0d",
                       o_out_word.status, o_out_word.removed_value);
                fail_cnt++;
            end else begin
                want = result_q.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_word.status);
                    fail_cnt++;
                end
                if (o_out_word.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed_value, o_out_word.removed_value);
                    fail_cnt++;
                end
                if (o_out_word.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, o_out_word.occupancy);
                    fail_cnt++;
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
